// ===== rtl/ftd_pkg.sv =====
// ----------------------------------------------------------------------------
// ftd_pkg: shared constants and types for the float to decimal text unit
// Character codes, digit limits and the fraction word carried between units.
// ----------------------------------------------------------------------------
package ftd_pkg;

    localparam int MAX_FRAC_DIGITS = 32;

    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_POINT = 8'd46;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    // fraction LSB weight is 2^(scale - FRAC_LSB_EXP)
    localparam logic [7:0] FRAC_LSB_EXP = 8'd149;

    // remaining fraction: mant * 2^(scale - 149), mant below 2^24
    typedef struct packed {
        logic [23:0] mant;
        logic [7:0]  scale;
    } t_frac;

endpackage

// ===== rtl/ftd_mul10.sv =====
// ----------------------------------------------------------------------------
// ftd_mul10: fraction times ten, single-precision rounding
// Exact product of the fraction word and ten, rounded to nearest even on the
// single-precision grid (subnormal floor included).
// ----------------------------------------------------------------------------
module ftd_mul10 (
    input  ftd_pkg::t_frac i_frac,
    output ftd_pkg::t_frac o_frac
);

    logic [27:0] w_prod;
    logic [2:0]  w_s;
    logic [27:0] w_q;
    logic [27:0] w_rem;
    logic [27:0] w_half;
    logic        w_up;
    logic [24:0] w_sum;

    always_comb begin
        w_prod = {1'b0, i_frac.mant, 3'b0} + {3'b0, i_frac.mant, 1'b0};
        // bits to drop so that 24 significant bits remain
        w_s = 3'd0;
        for (int b = 24; b < 28; b++) begin
            if (w_prod[b]) begin
                w_s = 3'(b - 23);
            end
        end
        w_q    = w_prod >> w_s;
        w_rem  = w_prod & ~(28'hFFF_FFFF << w_s);
        w_half = (w_s == 3'd0) ? 28'd0 : (28'd1 << (w_s - 3'd1));
        w_up   = (w_s != 3'd0) &&
                 ((w_rem > w_half) || ((w_rem == w_half) && w_q[0]));
        w_sum  = w_q[24:0] + 25'(w_up);
        if (w_sum[24]) begin
            o_frac.mant  = w_sum[24:1];
            o_frac.scale = i_frac.scale + 8'(w_s) + 8'd1;
        end else begin
            o_frac.mant  = w_sum[23:0];
            o_frac.scale = i_frac.scale + 8'(w_s);
        end
    end

endmodule

// ===== rtl/float_to_decimal_text.sv =====
// ----------------------------------------------------------------------------
// float_to_decimal_text_unit: single-precision value to fixed decimal text
// Sign, integer digits, point and fraction digits, one ASCII word a result.
// ----------------------------------------------------------------------------
// Usage notes
// - Command port: a word (i_value_bits, i_frac_digits) is taken on a rising
//   edge with start high and busy low. busy stays high until the last
//   character has gone out.
// - Result port: o_strobe marks each character for exactly one cycle; the
//   receiver must take it then, there is no back-pressure.
// - NaN/infinity: one word with o_invalid and o_last set, char 0, the cycle
//   after accept; busy never rises.
// - Sequence: '-' (if negative) the cycle after accept; then binary to BCD
//   shifting (one shared add-3/shift step), integer digits (leading zeros
//   skipped silently), '.', then for each fraction digit
//   multiply-by-ten/round, then extract.
// - Pacing: one value at a time, set by the double-dabble loop and the
//   shared x10 unit; a new command is taken only with busy low.
// - frac digits above 32 are clamped to 32. Integer part at or above 2^63
//   saturates to 2^63-1.
// - Reset (synchronous, active low) returns to idle and drops the strobe.
// ----------------------------------------------------------------------------
module float_to_decimal_text_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_value_bits,
    input  logic [5:0]  i_frac_digits,
    output logic        o_strobe,
    output logic [7:0]  o_char_code,
    output logic        o_last,
    output logic        o_invalid
);

    typedef enum logic [2:0] {
        S_IDLE, S_CONV, S_INT, S_POINT, S_MUL, S_DIG
    } t_state;

    t_state r_state, n_state;
    logic [63:0] r_bin, n_bin;
    logic [79:0] r_bcd, n_bcd;
    logic [5:0]  r_cnt, n_cnt;
    logic [5:0]  r_fcnt, n_fcnt;
    logic        r_started, n_started;
    ftd_pkg::t_frac r_frac, n_frac;
    logic        r_strobe, n_strobe;
    logic [7:0]  r_char, n_char;
    logic        r_last, n_last;
    logic        r_invalid, n_invalid;

    // input decode
    logic [7:0]  w_exp;
    logic [23:0] w_mfull;
    logic [4:0]  w_rsh;
    logic [5:0]  w_lsh;
    logic [63:0] w_ipart;
    ftd_pkg::t_frac w_frac0;
    logic        w_neg;
    logic [5:0]  w_digits;

    // BCD step
    logic [79:0] w_adj;

    // fraction path
    ftd_pkg::t_frac w_prod;
    logic [7:0]  w_sh;
    logic [23:0] w_wide;
    logic [3:0]  w_digit;
    ftd_pkg::t_frac w_rem;

    ftd_mul10 u_mul10 (
        .i_frac (r_frac),
        .o_frac (w_prod)
    );

    always_comb begin
        w_exp   = i_value_bits[30:23];
        w_mfull = {(w_exp != 8'd0), i_value_bits[22:0]};
        w_rsh   = 5'(8'd150 - w_exp);
        w_lsh   = 6'(w_exp - 8'd150);
        w_neg   = i_value_bits[31] && (i_value_bits[30:0] != 31'd0);
        w_digits = (i_frac_digits > 6'(ftd_pkg::MAX_FRAC_DIGITS)) ?
                   6'(ftd_pkg::MAX_FRAC_DIGITS) : i_frac_digits;
        w_frac0 = '0;
        if (w_exp == 8'd0) begin
            w_ipart      = 64'd0;
            w_frac0.mant = w_mfull;
        end else if (w_exp < 8'd127) begin
            w_ipart       = 64'd0;
            w_frac0.mant  = w_mfull;
            w_frac0.scale = w_exp - 8'd1;
        end else if (w_exp < 8'd150) begin
            w_ipart       = 64'(w_mfull >> w_rsh);
            w_frac0.mant  = w_mfull & ~(24'hFF_FFFF << w_rsh);
            w_frac0.scale = w_exp - 8'd1;
        end else if (w_exp < 8'd190) begin
            w_ipart = {40'd0, w_mfull} << w_lsh;
        end else begin
            w_ipart = 64'h7FFF_FFFF_FFFF_FFFF;
        end
    end

    // add-3 correction on every BCD digit
    always_comb begin
        for (int i = 0; i < 20; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ?
                              r_bcd[4*i +: 4] + 4'd3 : r_bcd[4*i +: 4];
        end
    end

    // digit = integer part of the scaled fraction
    always_comb begin
        w_sh   = ftd_pkg::FRAC_LSB_EXP - r_frac.scale;
        w_wide = 24'd0;
        w_rem  = r_frac;
        if (w_sh < 8'd24) begin
            w_wide     = r_frac.mant >> w_sh[4:0];
            w_rem.mant = r_frac.mant & ~(24'hFF_FFFF << w_sh[4:0]);
        end
        w_digit = w_wide[3:0];
        if (w_wide >= 24'd10) begin
            // rounded up to ten: clamp
            w_digit = 4'd9;
            w_rem   = '0;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_fcnt    = r_fcnt;
        n_started = r_started;
        n_frac    = r_frac;
        n_strobe  = 1'b0;
        n_char    = r_char;
        n_last    = 1'b0;
        n_invalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (w_exp == 8'hFF) begin
                        n_strobe  = 1'b1;
                        n_char    = ftd_pkg::CHAR_NUL;
                        n_last    = 1'b1;
                        n_invalid = 1'b1;
                    end else begin
                        if (w_neg) begin
                            n_strobe = 1'b1;
                            n_char   = ftd_pkg::CHAR_MINUS;
                        end
                        n_bin     = w_ipart;
                        n_bcd     = '0;
                        n_frac    = w_frac0;
                        n_fcnt    = w_digits;
                        n_cnt     = 6'd63;
                        n_started = 1'b0;
                        n_state   = S_CONV;
                    end
                end
            end
            S_CONV: begin
                n_bcd = {w_adj[78:0], r_bin[63]};
                n_bin = {r_bin[62:0], 1'b0};
                if (r_cnt == 6'd0) begin
                    n_cnt   = 6'd19;
                    n_state = S_INT;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_INT: begin
                if ((r_bcd[79:76] != 4'd0) || r_started || (r_cnt == 6'd0)) begin
                    n_strobe  = 1'b1;
                    n_char    = ftd_pkg::CHAR_ZERO + {4'd0, r_bcd[79:76]};
                    n_started = 1'b1;
                end
                n_bcd = {r_bcd[75:0], 4'd0};
                if (r_cnt == 6'd0) begin
                    n_state = S_POINT;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_POINT: begin
                n_strobe = 1'b1;
                n_char   = ftd_pkg::CHAR_POINT;
                n_last   = (r_fcnt == 6'd0);
                n_state  = (r_fcnt == 6'd0) ? S_IDLE : S_MUL;
            end
            S_MUL: begin
                n_frac  = w_prod;
                n_state = S_DIG;
            end
            S_DIG: begin
                n_strobe = 1'b1;
                n_char   = ftd_pkg::CHAR_ZERO + {4'd0, w_digit};
                n_frac   = w_rem;
                n_fcnt   = r_fcnt - 6'd1;
                n_last   = (r_fcnt == 6'd1);
                n_state  = (r_fcnt == 6'd1) ? S_IDLE : S_MUL;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_strobe  <= 1'b0;
            r_last    <= 1'b0;
            r_invalid <= 1'b0;
            r_started <= 1'b0;
            r_cnt     <= 6'd0;
            r_fcnt    <= 6'd0;
        end else begin
            r_state   <= n_state;
            r_strobe  <= n_strobe;
            r_last    <= n_last;
            r_invalid <= n_invalid;
            r_started <= n_started;
            r_cnt     <= n_cnt;
            r_fcnt    <= n_fcnt;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_frac <= n_frac;
        r_char <= n_char;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_last      = r_last;
    assign o_invalid   = r_invalid;

endmodule

// ===== rtl/ftd_checker.sv =====
// ----------------------------------------------------------------------------
// ftd_checker: port-level checks for the float to decimal text unit
// Watches the command and result ports only; bound to the top level.
// ----------------------------------------------------------------------------
module ftd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] i_value_bits,
    input logic        o_strobe,
    input logic [7:0]  o_char_code,
    input logic        o_last,
    input logic        o_invalid
);

    a_invalid_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_invalid |-> o_last && (o_char_code == ftd_pkg::CHAR_NUL))
        else $error("invalid word not a lone last word");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_invalid |-> (o_char_code == ftd_pkg::CHAR_MINUS) ||
            (o_char_code == ftd_pkg::CHAR_POINT) ||
            ((o_char_code >= ftd_pkg::CHAR_ZERO) &&
             (o_char_code <= ftd_pkg::CHAR_ZERO + 8'd9)))
        else $error("unexpected character");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_value_bits[30:23] != 8'hFF) |=> busy)
        else $error("busy not raised after a valid command");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("still busy after last word");

    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last flag without strobe");

endmodule

bind float_to_decimal_text_unit ftd_checker u_ftd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_value_bits (i_value_bits),
    .o_strobe     (o_strobe),
    .o_char_code  (o_char_code),
    .o_last       (o_last),
    .o_invalid    (o_invalid)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for float_to_decimal_text_unit
// Single-precision values go in as command words; each character word that
// comes back is checked against an exact integer model of the conversion.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        logic [31:0] value_bits;
        logic [5:0]  frac_digits;
        bit          drain_first;   // hold off until every character is in
    } t_cmd;

    typedef struct {
        logic [7:0] char_code;
        logic       last;
        logic       invalid;
    } t_char;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_value_bits;
    logic [5:0]  i_frac_digits;
    logic        o_strobe;
    logic [7:0]  o_char_code;
    logic        o_last;
    logic        o_invalid;

    t_cmd  cmd_q[$];
    t_char text_q[$];
    int    mismatches;
    int    cycles;
    logic  taken;
    int    burst_left;
    int    gap_left;

    float_to_decimal_text_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value_bits  (i_value_bits),
        .i_frac_digits (i_frac_digits),
        .o_strobe      (o_strobe),
        .o_char_code   (o_char_code),
        .o_last        (o_last),
        .o_invalid     (o_invalid)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------------
    // Expected text for one value. The remaining fraction is held exactly as
    // rem * 2^-sh; multiplying by ten is then rounded to 24 significant bits,
    // nearest even, just as a single-precision multiply would.
    // ------------------------------------------------------------------------
    task automatic push_char(input logic [7:0] ch);
        t_char c;
        c.char_code = ch;
        c.last      = 1'b0;
        c.invalid   = 1'b0;
        text_q.push_back(c);
    endtask

    task automatic predict_text(input logic [31:0] bits, input logic [5:0] ndig);
        t_char       c;
        logic [7:0]  expo;
        logic [63:0] sig;
        logic [63:0] ipart;
        logic [63:0] rem;
        logic [63:0] prod;
        logic [63:0] low;
        logic [63:0] half;
        logic [63:0] d;
        logic [3:0]  dec[20];
        int          sh;
        int          nb;
        int          k;
        int          n;
        int          digits;
        expo = bits[30:23];
        if (expo == 8'hFF) begin
            c.char_code = ftd_pkg::CHAR_NUL;
            c.last      = 1'b1;
            c.invalid   = 1'b1;
            text_q.push_back(c);
            return;
        end
        digits = (ndig > ftd_pkg::MAX_FRAC_DIGITS) ? ftd_pkg::MAX_FRAC_DIGITS : ndig;
        // negative zero prints no sign
        if (bits[31] && bits[30:0] != 31'd0)
            push_char(ftd_pkg::CHAR_MINUS);
        if (expo == 8'd0) begin
            ipart = 64'd0;
            rem   = {41'd0, bits[22:0]};
            sh    = 149;
        end else begin
            sig = {40'd0, 1'b1, bits[22:0]};
            if (expo >= 8'd190) begin
                ipart = 64'h7FFF_FFFF_FFFF_FFFF;
                rem   = 64'd0;
                sh    = 0;
            end else if (expo >= 8'd150) begin
                ipart = sig << (expo - 8'd150);
                rem   = 64'd0;
                sh    = 0;
            end else begin
                sh    = 150 - expo;
                ipart = sig >> sh;
                rem   = (sh >= 64) ? sig : (sig & ((64'd1 << sh) - 64'd1));
            end
        end
        n = 0;
        do begin
            dec[n] = 4'(ipart % 64'd10);
            ipart  = ipart / 64'd10;
            n++;
        end while (ipart != 0 && n < 20);
        while (n > 0) begin
            n--;
            push_char(ftd_pkg::CHAR_ZERO + {4'd0, dec[n]});
        end
        push_char(ftd_pkg::CHAR_POINT);
        for (int i = 0; i < digits; i++) begin
            prod = rem * 64'd10;
            nb = 0;
            for (int b = 0; b < 64; b++)
                if (prod[b]) nb = b + 1;
            if (nb > 24) begin
                k    = nb - 24;
                low  = prod & ((64'd1 << k) - 64'd1);
                half = 64'd1 << (k - 1);
                prod = prod >> k;
                if (low > half || (low == half && prod[0]))
                    prod++;
                sh -= k;
            end
            d = (sh >= 64) ? 64'd0 : (prod >> sh);
            if (d >= 64'd10) begin
                // rounded up to ten: digit clamped to nine, nothing left over
                d   = 64'd9;
                rem = 64'd0;
            end else begin
                rem = (sh >= 64) ? prod : (prod - (d << sh));
            end
            push_char(ftd_pkg::CHAR_ZERO + d[7:0]);
        end
        text_q[$].last = 1'b1;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample on the rising edge, predict on accept, check each word.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_char want;
        cycles <= cycles + 1;
        taken  <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (start && !busy)
                predict_text(i_value_bits, i_frac_digits);
            if (o_strobe) begin
                if (text_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %h", o_char_code));
                end else begin
                    want = text_q.pop_front();
                    if (o_char_code !== want.char_code)
                        report_mismatch($sformatf("char %h, want %h",
                                                  o_char_code, want.char_code));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %b, want %b",
                                                  o_last, want.last));
                    if (o_invalid !== want.invalid)
                        report_mismatch($sformatf("invalid %b, want %b",
                                                  o_invalid, want.invalid));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: changes on the falling edge. A word stays up until taken; the
    // sender runs in bursts with random gaps between them.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (cmd_q.size() == 0) begin
                start <= 1'b0;
            end else if (cmd_q[0].drain_first && (text_q.size() != 0 || busy)) begin
                start <= 1'b0;
            end else begin
                t_cmd c;
                c = cmd_q.pop_front();
                i_value_bits  <= c.value_bits;
                i_frac_digits <= c.frac_digits;
                start         <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 8);
                    // long runs with no gap now and then
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    task automatic add_cmd(input logic [31:0] v, input logic [5:0] n, input bit drain);
        t_cmd c;
        c.value_bits  = v;
        c.frac_digits = n;
        c.drain_first = drain;
        cmd_q.push_back(c);
    endtask

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] v;
        logic [5:0]  n;
        mismatches    = 0;
        cycles        = 0;
        taken         = 1'b0;
        burst_left    = 1;
        gap_left      = 0;
        start         = 1'b0;
        i_value_bits  = 32'd0;
        i_frac_digits = 6'd0;
        i_rst_n       = 1'b0;

        // directed: zeros, signs, specials, extremes, clamps
        add_cmd(32'h0000_0000, 6'd0,  1'b0);
        add_cmd(32'h8000_0000, 6'd3,  1'b0);   // negative zero
        add_cmd(32'h3FC0_0000, 6'd2,  1'b0);   // 1.5
        add_cmd(32'hC010_0000, 6'd4,  1'b0);   // -2.25
        add_cmd(32'h7FC0_0000, 6'd5,  1'b0);   // quiet NaN
        add_cmd(32'hFF80_0001, 6'd5,  1'b0);   // negative signalling NaN
        add_cmd(32'h7F80_0000, 6'd1,  1'b0);   // +inf
        add_cmd(32'hFF80_0000, 6'd1,  1'b0);   // -inf
        add_cmd(32'h5F00_0000, 6'd2,  1'b0);   // exactly 2^63, saturates
        add_cmd(32'h5EFF_FFFF, 6'd2,  1'b0);   // just below 2^63
        add_cmd(32'hFF7F_FFFF, 6'd63, 1'b0);   // most negative finite
        add_cmd(32'h0000_0001, 6'd32, 1'b0);   // smallest denormal
        add_cmd(32'h807F_FFFF, 6'd40, 1'b0);   // negative largest denormal
        add_cmd(32'h3DCC_CCCD, 6'd32, 1'b0);   // 0.1
        add_cmd(32'h4B00_0001, 6'd4,  1'b0);   // 2^23 + 1, no fraction
        add_cmd(32'h3F7F_FFFF, 6'd12, 1'b0);   // just below one, x10 rounds down
        add_cmd(32'h42F6_E979, 6'd6,  1'b1);   // 123.456 after a drain
        add_cmd(32'h4996_02D2, 6'd33, 1'b0);   // digit count clamped
        add_cmd(32'h7F7F_FFFF, 6'd0,  1'b0);

        for (int i = 0; i < 250; i++) begin
            case ($urandom_range(0, 3))
                0:       v = $urandom;
                1:       v = {1'($urandom), 8'($urandom_range(100, 160)), 23'($urandom)};
                2:       v = {1'($urandom), 8'($urandom_range(118, 134)), 23'($urandom)};
                default: v = {1'($urandom), 8'($urandom_range(150, 200)), 23'($urandom)};
            endcase
            n = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8));
            add_cmd(v, n, $urandom_range(0, 40) == 0);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (cmd_q.size() != 0 || start || text_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && text_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
